/* rtl/core/assert_macros.svh */
// assertion macros shared by the axis tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define APT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("axis tracker assertion failed");

// next-cycle implication, checked on every rising clk edge outside reset
`define APT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("axis tracker assertion failed");

`endif

/* rtl/core/apt_pkg.sv */
// types and constants for the axis position limit tracker
package apt_pkg;

  localparam int unsigned APB_ADDR_W = 5;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DISPLAY_MODE = 3'd0;
  localparam logic [2:0] REG_ZERO_WINDOW  = 3'd1;
  localparam logic [2:0] REG_LIMIT_CHOICE = 3'd2;
  localparam logic [2:0] REG_UNSET_MIN    = 3'd3;
  localparam logic [2:0] REG_UNSET_MAX    = 3'd4;

  // operation codes
  localparam logic [2:0] OP_QUERY     = 3'd0;
  localparam logic [2:0] OP_STEP_UP   = 3'd1;
  localparam logic [2:0] OP_STEP_DOWN = 3'd2;
  localparam logic [2:0] OP_ZERO_HERE = 3'd3;
  localparam logic [2:0] OP_CAPTURE   = 3'd4;
  localparam logic [2:0] OP_RESET_POS = 3'd5;

  // display modes
  localparam logic [1:0] DISP_NORMAL    = 2'd0;
  localparam logic [1:0] DISP_CALIBRATE = 2'd1;

  // limit choices
  localparam logic [1:0] CHOICE_NONE = 2'd0;
  localparam logic [1:0] CHOICE_MIN  = 2'd1;
  localparam logic [1:0] CHOICE_MAX  = 2'd2;

  // register reset values
  localparam logic [1:0]  DISPLAY_MODE_RST = DISP_NORMAL;
  localparam logic [30:0] ZERO_WINDOW_RST  = 31'd10;
  localparam logic [1:0]  LIMIT_CHOICE_RST = CHOICE_NONE;
  localparam logic [31:0] UNSET_MIN_RST    = 32'h8000_0000;
  localparam logic [31:0] UNSET_MAX_RST    = 32'h7fff_ffff;

  // blink timing in milliseconds
  localparam logic [9:0] SLOW_HALF   = 10'd500;
  localparam logic [9:0] FAST_PERIOD = 10'd500;
  localparam logic [9:0] FAST_HALF   = 10'd250;
  // 1000 = 8 * 125, residue taken mod 125 by folding 2^7 = 3 (mod 125)
  localparam logic [7:0] FOLD_MOD    = 8'd125;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] ms_time;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] position_now;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic               zeroed_once;
    logic               capture_refused;
    logic               led_lower;
    logic               led_upper;
    logic               led_in_range;
    logic               led_active;
  } rsp_t;

  typedef struct packed {
    logic slow;
    logic fast;
  } blink_t;

endpackage

/* rtl/core/axis_position_limit_tracker.sv */
// axis position limit tracker: step counting, limit capture and status leds
// a command moves through the stage 1, 2 and 3 registers into the result register
// throughput: one transaction per cycle; cmd_ready is high whenever the result
//   register is empty or is being emptied in the same cycle
// reset (rst, synchronous): position 0, not zeroed, limits at the unset values,
//   registers at their reset values, pipeline empty
`include "assert_macros.svh"

module axis_position_limit_tracker import apt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_t                  cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp
);

  // configuration registers
  logic [1:0]  display_mode;
  logic [30:0] zero_window;
  logic [1:0]  limit_choice;
  logic [31:0] unset_min_value;
  logic [31:0] unset_max_value;

  // architectural state
  logic [31:0] axis_position;
  logic [31:0] min_limit_store;
  logic [31:0] max_limit_store;
  logic        was_zeroed;

  logic [31:0] axis_position_next;
  logic [31:0] min_limit_store_next;
  logic [31:0] max_limit_store_next;
  logic        was_zeroed_next;
  logic        refused_next;

  // pipeline
  logic        en;
  logic        v1, v2, v3;
  cmd_t        s1_cmd;
  logic [31:0] s2_pos, s2_min, s2_max;
  logic        s2_zeroed, s2_refused;
  logic signed [31:0] s3_pos, s3_min, s3_max;
  logic        s3_zeroed, s3_refused;
  logic        s3_below, s3_above, s3_at_zero, s3_min_unset, s3_max_unset;
  logic        below_next, above_next, at_zero_next;
  logic signed [32:0] pos_wide, win_wide;
  blink_t      blink;
  rsp_t        rsp_next;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode    <= DISPLAY_MODE_RST;
      zero_window     <= ZERO_WINDOW_RST;
      limit_choice    <= LIMIT_CHOICE_RST;
      unset_min_value <= UNSET_MIN_RST;
      unset_max_value <= UNSET_MAX_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DISPLAY_MODE: display_mode    <= pwdata[1:0];
        REG_ZERO_WINDOW:  zero_window     <= pwdata[30:0];
        REG_LIMIT_CHOICE: limit_choice    <= pwdata[1:0];
        REG_UNSET_MIN:    unset_min_value <= pwdata;
        REG_UNSET_MAX:    unset_max_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DISPLAY_MODE: prdata = 32'(display_mode);
      REG_ZERO_WINDOW:  prdata = 32'(zero_window);
      REG_LIMIT_CHOICE: prdata = 32'(limit_choice);
      REG_UNSET_MIN:    prdata = unset_min_value;
      REG_UNSET_MAX:    prdata = unset_max_value;
      default:          prdata = 32'd0;
    endcase
  end

  assign en        = !rsp_valid || rsp_ready;
  assign cmd_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v1        <= cmd_valid;
      v2        <= v1;
      v3        <= v2;
      rsp_valid <= v3;
    end
  end

  // stage 1: command register
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd <= cmd;
    end
  end

  // state update on the command leaving stage 1
  always_comb begin
    axis_position_next   = axis_position;
    min_limit_store_next = min_limit_store;
    max_limit_store_next = max_limit_store;
    was_zeroed_next      = was_zeroed;
    refused_next         = 1'b0;
    case (s1_cmd.operation)
      OP_STEP_UP:   axis_position_next = axis_position + 32'd1;
      OP_STEP_DOWN: axis_position_next = axis_position - 32'd1;
      OP_ZERO_HERE: begin
        axis_position_next = 32'd0;
        was_zeroed_next    = 1'b1;
      end
      OP_CAPTURE: begin
        if (!was_zeroed) begin
          refused_next = 1'b1;
        end else if (limit_choice == CHOICE_MAX) begin
          max_limit_store_next = axis_position;
        end else if (limit_choice == CHOICE_MIN) begin
          min_limit_store_next = axis_position;
        end
      end
      OP_RESET_POS: begin
        axis_position_next   = 32'd0;
        min_limit_store_next = unset_min_value;
        max_limit_store_next = unset_max_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_position   <= 32'd0;
      min_limit_store <= UNSET_MIN_RST;
      max_limit_store <= UNSET_MAX_RST;
      was_zeroed      <= 1'b0;
    end else if (en && v1) begin
      axis_position   <= axis_position_next;
      min_limit_store <= min_limit_store_next;
      max_limit_store <= max_limit_store_next;
      was_zeroed      <= was_zeroed_next;
    end
  end

  // stage 2: state snapshot after the transaction
  always_ff @(posedge clk) begin
    if (en) begin
      s2_pos     <= axis_position_next;
      s2_min     <= min_limit_store_next;
      s2_max     <= max_limit_store_next;
      s2_zeroed  <= was_zeroed_next;
      s2_refused <= refused_next;
    end
  end

  always_comb begin
    pos_wide     = 33'(signed'(s2_pos));
    win_wide     = signed'({2'b00, zero_window});
    below_next   = signed'(s2_pos) <= signed'(s2_min);
    above_next   = signed'(s2_pos) >= signed'(s2_max);
    at_zero_next = (pos_wide <= win_wide) && (pos_wide >= -win_wide);
  end

  // stage 3: compares
  always_ff @(posedge clk) begin
    if (en) begin
      s3_pos       <= signed'(s2_pos);
      s3_min       <= signed'(s2_min);
      s3_max       <= signed'(s2_max);
      s3_zeroed    <= s2_zeroed;
      s3_refused   <= s2_refused;
      s3_below     <= below_next;
      s3_above     <= above_next;
      s3_at_zero   <= at_zero_next;
      s3_min_unset <= (s2_min == unset_min_value);
      s3_max_unset <= (s2_max == unset_max_value);
    end
  end

  apt_blink u_blink (
    .clk     (clk),
    .en      (en),
    .ms_time (s1_cmd.ms_time),
    .blink   (blink)
  );

  always_comb begin
    rsp_next.position_now    = s3_pos;
    rsp_next.lower_limit     = s3_min;
    rsp_next.upper_limit     = s3_max;
    rsp_next.zeroed_once     = s3_zeroed;
    rsp_next.capture_refused = s3_refused;
    rsp_next.led_lower       = 1'b0;
    rsp_next.led_upper       = 1'b0;
    rsp_next.led_in_range    = 1'b0;
    rsp_next.led_active      = 1'b0;
    case (display_mode)
      DISP_NORMAL: begin
        rsp_next.led_lower = s3_min_unset ? blink.fast : s3_below;
        rsp_next.led_upper = s3_max_unset ? blink.fast : s3_above;
        if (!s3_zeroed) begin
          rsp_next.led_in_range = blink.fast;
        end else if (s3_at_zero) begin
          rsp_next.led_in_range = blink.slow;
        end else begin
          rsp_next.led_in_range = !s3_below && !s3_above;
        end
        rsp_next.led_active = blink.fast;
      end
      DISP_CALIBRATE: begin
        rsp_next.led_lower    = (limit_choice == CHOICE_MIN) ? (s3_below ^ blink.slow)
                                                             : s3_below;
        rsp_next.led_upper    = (limit_choice == CHOICE_MAX) ? (s3_above ^ blink.slow)
                                                             : s3_above;
        rsp_next.led_in_range = !s3_below && !s3_above;
        rsp_next.led_active   = blink.slow;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  `APT_ASSERT_NOW(a_refused_not_zeroed, rsp_valid && rsp.capture_refused, !rsp.zeroed_once)
  `APT_ASSERT_NEXT(a_zeroed_sticky, was_zeroed, was_zeroed)
  `APT_ASSERT_NOW(a_leds_off_other_mode,
                  rsp_valid && display_mode != DISP_NORMAL && display_mode != DISP_CALIBRATE,
                  !rsp.led_lower && !rsp.led_upper && !rsp.led_in_range && !rsp.led_active)
  `APT_ASSERT_NEXT(a_state_holds_on_stall, !en, $stable(axis_position) && $stable(was_zeroed))

endmodule

/* rtl/core/apt_blink.sv */
// blink phase unit: ms_time mod 1000 and mod 500 over two register stages
module apt_blink import apt_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ms_time,
  output blink_t      blink
);

  logic [28:0] x0;
  logic [23:0] f1;
  logic [18:0] f2;
  logic [13:0] f3;
  logic [8:0]  f4;
  logic [7:0]  f5;
  logic [6:0]  m125;
  logic [9:0]  r1000;
  logic [9:0]  r500;

  logic [18:0] a_fold;
  logic [2:0]  a_low;
  logic [8:0]  b_fold;
  logic [2:0]  b_low;

  always_comb begin
    x0 = ms_time[31:3];
    f1 = 24'(x0[28:7]) * 24'd3 + 24'(x0[6:0]);
    f2 = 19'(f1[23:7]) * 19'd3 + 19'(f1[6:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_fold <= f2;
      a_low  <= ms_time[2:0];
    end
  end

  always_comb begin
    f3 = 14'(a_fold[18:7]) * 14'd3 + 14'(a_fold[6:0]);
    f4 = 9'(f3[13:7]) * 9'd3 + 9'(f3[6:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_fold <= f4;
      b_low  <= a_low;
    end
  end

  always_comb begin
    f5    = 8'(b_fold[8:7]) * 8'd3 + 8'(b_fold[6:0]);
    m125  = (f5 >= FOLD_MOD) ? 7'(f5 - FOLD_MOD) : f5[6:0];
    r1000 = {m125, b_low};
    r500  = (r1000 >= FAST_PERIOD) ? (r1000 - FAST_PERIOD) : r1000;
    blink.slow = (r1000 > SLOW_HALF);
    blink.fast = (r500 > FAST_HALF);
  end

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the axis position limit tracker
module tb import apt_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned NUM_DIR_ROWS = 37;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [1:0] MODE_BLANK_A = 2'd2;
  localparam logic [1:0] MODE_BLANK_B = 2'd3;
  localparam logic [1:0] CHOICE_IDLE = 2'd3;
  localparam logic [31:0] UNSET_LOW_INIT = 32'h8000_0000;
  localparam logic [31:0] UNSET_HIGH_INIT = 32'h7fff_ffff;
  localparam logic [31:0] MS_SLOW_PERIOD = 32'd1000;
  localparam logic [31:0] MS_SLOW_HALF = 32'd500;
  localparam logic [31:0] MS_FAST_PERIOD = 32'd500;
  localparam logic [31:0] MS_FAST_HALF = 32'd250;

  typedef enum logic [1:0] {ROW_CHECKED, ROW_PREDICTED, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    cmd_t        c;
    rsp_t        want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  cmd_valid;
  logic                  cmd_ready;
  cmd_t                  cmd;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;

  // tracker model state and registers
  logic [1:0]  disp_mode = DISP_NORMAL;
  logic [30:0] zero_win = 31'd10;
  logic [1:0]  lim_choice = CHOICE_NONE;
  logic [31:0] unset_min = UNSET_LOW_INIT;
  logic [31:0] unset_max = UNSET_HIGH_INIT;
  logic [31:0] axis_pos = '0;
  logic [31:0] min_lim = UNSET_LOW_INIT;
  logic [31:0] max_lim = UNSET_HIGH_INIT;
  logic        zeroed = 1'b0;

  rsp_t        pending_status[$];
  rsp_t        want_rsp;
  dir_row_t    dir_rows [NUM_DIR_ROWS];
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned faults = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned limits_taken = 0;

  axis_position_limit_tracker DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic rsp_t track_axis(cmd_t c);
    rsp_t   r;
    logic   slow, fast, below, above, at_zero;
    longint p, w;
    r = '0;
    case (c.operation)
      OP_STEP_UP: axis_pos = axis_pos + 32'd1;
      OP_STEP_DOWN: axis_pos = axis_pos - 32'd1;
      OP_ZERO_HERE: begin
        axis_pos = '0;
        zeroed = 1'b1;
      end
      OP_CAPTURE: begin
        if (!zeroed) begin
          r.capture_refused = 1'b1;
        end else if (lim_choice == CHOICE_MAX) begin
          max_lim = axis_pos;
          limits_taken++;
        end else if (lim_choice == CHOICE_MIN) begin
          min_lim = axis_pos;
          limits_taken++;
        end
      end
      OP_RESET_POS: begin
        min_lim = unset_min;
        max_lim = unset_max;
        axis_pos = '0;
      end
      default: ;
    endcase
    slow = (c.ms_time % MS_SLOW_PERIOD) > MS_SLOW_HALF;
    fast = (c.ms_time % MS_FAST_PERIOD) > MS_FAST_HALF;
    below = $signed(axis_pos) <= $signed(min_lim);
    above = $signed(axis_pos) >= $signed(max_lim);
    p = longint'($signed(axis_pos));
    w = longint'(zero_win);
    at_zero = (p <= w) && (p >= -w);
    case (disp_mode)
      DISP_NORMAL: begin
        r.led_lower = (min_lim == unset_min) ? fast : below;
        r.led_upper = (max_lim == unset_max) ? fast : above;
        r.led_in_range = !zeroed ? fast : (at_zero ? slow : (!below && !above));
        r.led_active = fast;
      end
      DISP_CALIBRATE: begin
        r.led_lower = (lim_choice == CHOICE_MIN) ? (below ^ slow) : below;
        r.led_upper = (lim_choice == CHOICE_MAX) ? (above ^ slow) : above;
        r.led_in_range = !below && !above;
        r.led_active = slow;
      end
      default: ;
    endcase
    r.position_now = axis_pos;
    r.lower_limit = min_lim;
    r.upper_limit = max_lim;
    r.zeroed_once = zeroed;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    faults++;
    if (faults <= MAX_PRINTED) begin
      $display("mismatch at cycle %0d, %s: got %h, want %h", cycle_count, what, got, want);
    end
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic send_cmd(cmd_t c, bit use_typed, rsp_t typed_want);
    rsp_t guess;
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    guess = track_axis(c);
    pending_status.push_back(use_typed ? typed_want : guess);
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DISPLAY_MODE: disp_mode = value[1:0];
      REG_ZERO_WINDOW: zero_win = value[30:0];
      REG_LIMIT_CHOICE: lim_choice = value[1:0];
      REG_UNSET_MIN: unset_min = value;
      REG_UNSET_MAX: unset_max = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    case (idx)
      REG_DISPLAY_MODE: check_field("display_mode readback", prdata, 32'(disp_mode));
      REG_ZERO_WINDOW: check_field("zero_window readback", prdata, 32'(zero_win));
      REG_LIMIT_CHOICE: check_field("limit_choice readback", prdata, 32'(lim_choice));
      REG_UNSET_MIN: check_field("unset_min_value readback", prdata, unset_min);
      REG_UNSET_MAX: check_field("unset_max_value readback", prdata, unset_max);
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("transaction with nothing pending", rsp.position_now, 32'd0);
      end else begin
        want_rsp = pending_status.pop_front();
        check_field("position_now", rsp.position_now, want_rsp.position_now);
        check_field("lower_limit", rsp.lower_limit, want_rsp.lower_limit);
        check_field("upper_limit", rsp.upper_limit, want_rsp.upper_limit);
        check_field("zeroed_once", rsp.zeroed_once, want_rsp.zeroed_once);
        check_field("capture_refused", rsp.capture_refused, want_rsp.capture_refused);
        check_field("led_lower", rsp.led_lower, want_rsp.led_lower);
        check_field("led_upper", rsp.led_upper, want_rsp.led_upper);
        check_field("led_in_range", rsp.led_in_range, want_rsp.led_in_range);
        check_field("led_active", rsp.led_active, want_rsp.led_active);
        results_checked++;
      end
    end
  end

  // receiver backpressure
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left != 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    cmd_t        c;
    int unsigned pick;
    int unsigned step_bias;
    logic [1:0]  mode_sel;
    logic [1:0]  choice_sel;
    logic [30:0] win_sel;
    logic [31:0] low_sel;
    logic [31:0] high_sel;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_valid = 1'b0;
    cmd = '0;
    dir_rows = '{
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_QUERY, 32'd0},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd300},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'hffff_ffff},
        '{32'hffff_ffff, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_STEP_UP, 32'd251},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_ZERO_HERE, 32'd250},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd501},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_SPARE_A, 32'd999},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{ROW_CHECKED, 3'd0, 32'd0, '{OP_SPARE_B, 32'd1000},
        '{32'd0, UNSET_LOW_INIT, UNSET_HIGH_INIT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'd256}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'h8000_0000}, '0},
      '{ROW_REG_WRITE, REG_LIMIT_CHOICE, 32'(CHOICE_MIN), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd1499}, '0},
      '{ROW_REG_WRITE, REG_LIMIT_CHOICE, 32'(CHOICE_MAX), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_UP, 32'h5555_5555}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_UP, 32'haaaa_aaaa}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_UP, 32'd1750}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd2251}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_UP, 32'd0}, '0},
      '{ROW_REG_WRITE, REG_DISPLAY_MODE, 32'(DISP_CALIBRATE), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'd600}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'd100}, '0},
      '{ROW_REG_WRITE, REG_DISPLAY_MODE, 32'(MODE_BLANK_A), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_QUERY, 32'hffff_ffff}, '0},
      '{ROW_REG_WRITE, REG_DISPLAY_MODE, 32'(MODE_BLANK_B), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_STEP_DOWN, 32'd777}, '0},
      '{ROW_REG_WRITE, REG_DISPLAY_MODE, 32'(DISP_NORMAL), '0, '0},
      '{ROW_REG_WRITE, REG_ZERO_WINDOW, 32'd0, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_QUERY, 32'd900}, '0},
      '{ROW_REG_WRITE, REG_ZERO_WINDOW, 32'h7fff_ffff, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_QUERY, 32'd900}, '0},
      '{ROW_REG_WRITE, REG_UNSET_MIN, 32'hffff_fffe, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_QUERY, 32'd300}, '0},
      '{ROW_REG_WRITE, REG_LIMIT_CHOICE, 32'(CHOICE_IDLE), '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd1}, '0},
      '{ROW_REG_WRITE, REG_UNSET_MAX, 32'd5, '0, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_RESET_POS, 32'd260}, '0},
      '{ROW_PREDICTED, 3'd0, 32'd0, '{OP_CAPTURE, 32'd10}, '0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG_WRITE) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        sender_gap();
        send_cmd(dir_rows[i].c, dir_rows[i].kind == ROW_CHECKED, dir_rows[i].want);
      end
    end

    step_bias = 50;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      idle_on = (ph != NUM_PHASES - 1);
      mode_sel = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 1));
      choice_sel = (ph < 4) ? 2'((ph + 1) % 4) : 2'($urandom_range(1, 2));
      if (ph == 0) begin
        win_sel = '0;
      end else if (ph == 1) begin
        win_sel = 31'h7fff_ffff;
      end else if ($urandom_range(0, 3) == 0) begin
        win_sel = 31'($urandom());
      end else begin
        win_sel = 31'($urandom_range(0, 12));
      end
      if (ph == 0) begin
        low_sel = UNSET_LOW_INIT;
        high_sel = UNSET_HIGH_INIT;
      end else begin
        case ($urandom_range(0, 3))
          0: low_sel = UNSET_LOW_INIT;
          1: low_sel = $urandom();
          default: low_sel = 32'(int'($urandom_range(0, 40)) - 20);
        endcase
        case ($urandom_range(0, 3))
          0: high_sel = UNSET_HIGH_INIT;
          1: high_sel = $urandom();
          default: high_sel = 32'(int'($urandom_range(0, 40)) - 20);
        endcase
      end
      write_reg(REG_DISPLAY_MODE, 32'(mode_sel));
      write_reg(REG_ZERO_WINDOW, 32'(win_sel));
      write_reg(REG_LIMIT_CHOICE, 32'(choice_sel));
      write_reg(REG_UNSET_MIN, low_sel);
      write_reg(REG_UNSET_MAX, high_sel);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          step_bias = $urandom_range(20, 80);
        end
        pick = $urandom_range(0, 99);
        if (pick < 64) begin
          c.operation = ($urandom_range(0, 99) < step_bias) ? OP_STEP_UP : OP_STEP_DOWN;
        end else if (pick < 74) begin
          c.operation = OP_CAPTURE;
        end else if (pick < 80) begin
          c.operation = OP_ZERO_HERE;
        end else if (pick < 83) begin
          c.operation = OP_RESET_POS;
        end else if (pick < 95) begin
          c.operation = OP_QUERY;
        end else begin
          c.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end
        // half the times sit near a blink phase edge
        if ($urandom_range(0, 1)) begin
          c.ms_time = $urandom();
        end else begin
          c.ms_time = 32'($urandom_range(0, 4000000) * 1000
                          + ($urandom_range(0, 3) * 250 + $urandom_range(0, 2) + 999) % 1000);
        end
        sender_gap();
        send_cmd(c, 1'b0, '0);
      end
    end

    cmd_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transactions and %0d register writes, %0d limit captures",
             cmds_sent, reg_writes, limits_taken);
    $display("%0d results checked, %0d mismatches", results_checked, faults);
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
